/* rtl/core/temporal_bandpass_biquad_cascade_top_assert.svh */
// Assertion macros for the band-pass biquad cascade.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef TEMPORAL_BANDPASS_BIQUAD_CASCADE_TOP_ASSERT_SVH
`define TEMPORAL_BANDPASS_BIQUAD_CASCADE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define TBBC_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("tbbc assertion failed");
`define TBBC_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("tbbc assertion failed");
`else
`define TBBC_ASSERT_IMP(lbl, a, b)
`define TBBC_ASSERT_NXT(lbl, a, b)
`endif
`endif

/* rtl/core/tbbc_pkg.sv */
// Shared types, constants and arithmetic helpers of the band-pass cascade.
// No dependencies.
`default_nettype none
package tbbc_pkg;

    localparam int MAX_POSITIONS = 16384;
    localparam int POS_W         = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam int LIMIT_W       = 15;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 24;
    localparam int PIPE_DEPTH    = 6;
    localparam int FIFO_DEPTH    = 16;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
    localparam int OCC_W         = $clog2(FIFO_DEPTH + 1);
    localparam logic [15:0] MIN_WARMUP = 16'd16;
    localparam logic [15:0] FRAME_MAX  = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HP_GAIN   = 4'd0,
        CFG_HP_A1     = 4'd1,
        CFG_HP_A2     = 4'd2,
        CFG_LP_GAIN   = 4'd3,
        CFG_LP_A1     = 4'd4,
        CFG_LP_A2     = 4'd5,
        CFG_POSITIONS = 4'd6,
        CFG_WARMUP    = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic        [13:0] position;
        logic signed [15:0] sample;
    } sample_in_t;

    typedef struct packed {
        logic signed [15:0] filtered_sample;
        logic               ready_res;
        logic               position_error;
    } result_t;

    typedef struct packed {
        logic        [22:0] hp_gain;
        logic signed [23:0] hp_a1;
        logic signed [23:0] hp_a2;
        logic        [22:0] lp_gain;
        logic signed [23:0] lp_a1;
        logic signed [23:0] lp_a2;
    } coef_t;

    typedef struct packed {
        logic signed [31:0] hp_w1;
        logic signed [31:0] hp_w2;
        logic signed [31:0] lp_w1;
        logic signed [31:0] lp_w2;
    } state_word_t;

    typedef struct packed {
        logic             vld;
        logic [POS_W-1:0] pos;
        logic             err;
        logic             rdy;
    } tag_t;

    typedef struct packed {
        logic             we;
        logic [POS_W-1:0] addr;
        state_word_t      data;
    } mem_wr_t;

    // Round a Q.30 product to Q.8 with floor after the half-LSB offset.
    function automatic logic signed [63:0] rnd22(input logic signed [63:0] v);
        rnd22 = (v + 64'sd2097152) >>> 22;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            sat32 = 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            sat32 = 32'sh8000_0000;
        else
            sat32 = v[31:0];
    endfunction

    // Drop the eight fraction bits with rounding and clamp to 16 bits.
    function automatic logic signed [15:0] out16(input logic signed [31:0] y);
        logic signed [32:0] r;
        r = ($signed({y[31], y}) + 33'sd128) >>> 8;
        if (r > 33'sd32767)
            out16 = 16'sh7FFF;
        else if (r < -33'sd32768)
            out16 = 16'sh8000;
        else
            out16 = r[15:0];
    endfunction

endpackage
`default_nettype wire

/* rtl/core/temporal_bandpass_biquad_cascade_top.sv */
// Temporal band-pass cascade: each transfer carries one sample for one position
// and returns one result, in order. One item is taken per cycle when the input
// is not stalled; the per-position state sits in one single-port-read,
// single-port-write memory, and an item whose position still has a write-back
// in the six-stage pipeline is held at the input until that write lands. After
// reset a clearing pass zeroes every entry of the state memory, during which
// samples are stalled (configuration writes are taken throughout). A
// sixteen-entry result queue absorbs output stalls; input is stalled once queued
// plus in-flight results fill it.
`default_nettype none
module temporal_bandpass_biquad_cascade_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           sample_valid,
    output logic                                sample_stall,
    input  wire tbbc_pkg::sample_in_t           sample_item,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output tbbc_pkg::result_t                   result_item,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tbbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tbbc_pkg::CFG_DATA_W-1:0] cfg_data
);
    `include "temporal_bandpass_biquad_cascade_top_assert.svh"

    // Configuration registers.
    tbbc_pkg::coef_t             coef_reg;
    logic [tbbc_pkg::LIMIT_W-1:0] positions_reg;
    logic [15:0]                 warmup_reg;

    // Frame accounting and flow control.
    logic [15:0]                 frame_count_reg, frame_count_next;
    logic [tbbc_pkg::OCC_W-1:0]  occ_reg, occ_next;
    logic                        clearing_reg;
    logic [tbbc_pkg::POS_W-1:0]  clr_addr_reg;

    logic [tbbc_pkg::LIMIT_W-1:0] limit;
    logic [15:0]                 threshold;
    logic                        accept, pos_err, last_pos, hazard, push, pop;
    tbbc_pkg::tag_t              tag_in;
    tbbc_pkg::mem_wr_t           pipe_wr, mem_wr;
    tbbc_pkg::state_word_t       rdata;
    tbbc_pkg::result_t           pipe_result;

    assign cfg_ready = 1'b1;

    // Clamp the position count to the store depth and the warmup to its floor.
    assign limit     = (32'(positions_reg) > tbbc_pkg::MAX_POSITIONS)
                       ? tbbc_pkg::LIMIT_W'(tbbc_pkg::MAX_POSITIONS) : positions_reg;
    assign threshold = (warmup_reg < tbbc_pkg::MIN_WARMUP) ? tbbc_pkg::MIN_WARMUP : warmup_reg;
    assign pos_err   = (32'(sample_item.position) >= 32'(limit));
    assign last_pos  = (32'(sample_item.position) == 32'(limit) - 32'd1);

    // Stall while clearing, on a same-position hazard, or when results would overflow.
    assign sample_stall = clearing_reg || hazard
                          || (occ_reg == tbbc_pkg::OCC_W'(tbbc_pkg::FIFO_DEPTH));
    assign accept       = sample_valid && !sample_stall;
    assign pop          = result_valid && !result_stall;

    always_comb
    begin
        frame_count_next = frame_count_reg;
        if (accept && !pos_err && last_pos && frame_count_reg != tbbc_pkg::FRAME_MAX)
            frame_count_next = frame_count_reg + 16'd1;
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (accept && !pop)
            occ_next = occ_reg + 1'b1;
        else if (pop && !accept)
            occ_next = occ_reg - 1'b1;
    end

    assign tag_in.vld = accept;
    assign tag_in.pos = sample_item.position[tbbc_pkg::POS_W-1:0];
    assign tag_in.err = pos_err;
    assign tag_in.rdy = (frame_count_next >= threshold);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg        <= '0;
            positions_reg   <= 15'd16384;
            warmup_reg      <= 16'd16;
            frame_count_reg <= '0;
            occ_reg         <= '0;
            clearing_reg    <= 1'b1;
            clr_addr_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (tbbc_pkg::cfg_reg_t'(cfg_index))
                    tbbc_pkg::CFG_HP_GAIN:   coef_reg.hp_gain <= cfg_data[22:0];
                    tbbc_pkg::CFG_HP_A1:     coef_reg.hp_a1   <= cfg_data;
                    tbbc_pkg::CFG_HP_A2:     coef_reg.hp_a2   <= cfg_data;
                    tbbc_pkg::CFG_LP_GAIN:   coef_reg.lp_gain <= cfg_data[22:0];
                    tbbc_pkg::CFG_LP_A1:     coef_reg.lp_a1   <= cfg_data;
                    tbbc_pkg::CFG_LP_A2:     coef_reg.lp_a2   <= cfg_data;
                    tbbc_pkg::CFG_POSITIONS: positions_reg    <= cfg_data[14:0];
                    tbbc_pkg::CFG_WARMUP:    warmup_reg       <= cfg_data[15:0];
                    default: ;
                endcase
            end
            frame_count_reg <= frame_count_next;
            occ_reg         <= occ_next;
            // Advance the clearing sweep one entry a cycle; drop out at the last.
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (32'(clr_addr_reg) == tbbc_pkg::MAX_POSITIONS - 1)
                    clearing_reg <= 1'b0;
            end
        end
    end

    assign mem_wr = clearing_reg ? '{we: 1'b1, addr: clr_addr_reg, data: '0} : pipe_wr;

    tbbc_state_mem u_mem (
        .clk   (clk),
        .wr    (mem_wr),
        .raddr (sample_item.position[tbbc_pkg::POS_W-1:0]),
        .rdata (rdata)
    );

    tbbc_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef_reg),
        .tag_in    (tag_in),
        .sample    (sample_item.sample),
        .rdata     (rdata),
        .probe_pos (sample_item.position[tbbc_pkg::POS_W-1:0]),
        .hazard    (hazard),
        .wr        (pipe_wr),
        .push      (push),
        .result    (pipe_result)
    );

    tbbc_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (pipe_result),
        .valid     (result_valid),
        .stall     (result_stall),
        .data      (result_item)
    );

    // Occupancy counts every result owed, so it bounds the queue and covers each push.
    `TBBC_ASSERT_IMP(a_occ_bound, 1'b1, occ_reg <= tbbc_pkg::OCC_W'(tbbc_pkg::FIFO_DEPTH))
    `TBBC_ASSERT_IMP(a_push_owed, push, occ_reg != '0)
    `TBBC_ASSERT_IMP(a_no_wb_in_clear, pipe_wr.we, !clearing_reg)
    `TBBC_ASSERT_NXT(a_frames_rise, 1'b1, frame_count_reg >= $past(frame_count_reg))
endmodule
`default_nettype wire

/* rtl/core/tbbc_state_mem.sv */
// Per-position filter state store, one read and one write port, read registered.
// Depends on tbbc_pkg.
`default_nettype none
module tbbc_state_mem (
    input  wire logic                       clk,
    input  wire tbbc_pkg::mem_wr_t          wr,
    input  wire logic [tbbc_pkg::POS_W-1:0] raddr,
    output tbbc_pkg::state_word_t           rdata
);
    tbbc_pkg::state_word_t mem [tbbc_pkg::MAX_POSITIONS];
    tbbc_pkg::state_word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
            mem[wr.addr] <= wr.data;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

/* rtl/core/tbbc_pipe.sv */
// Six-stage arithmetic pipeline: both biquad sections and state write-back.
// Depends on tbbc_pkg; reads state from tbbc_state_mem in the cycle after issue.
`default_nettype none
module tbbc_pipe (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire tbbc_pkg::coef_t            coef,
    input  wire tbbc_pkg::tag_t             tag_in,
    input  wire logic signed [15:0]         sample,
    input  wire tbbc_pkg::state_word_t      rdata,
    input  wire logic [tbbc_pkg::POS_W-1:0] probe_pos,
    output logic                            hazard,
    output tbbc_pkg::mem_wr_t               wr,
    output logic                            push,
    output tbbc_pkg::result_t               result
);
    tbbc_pkg::tag_t tag_reg [tbbc_pkg::PIPE_DEPTH];

    logic signed [23:0] x1_reg;
    logic signed [47:0] gx2_reg, gx3_reg, gx4_reg;
    tbbc_pkg::state_word_t st2_reg;
    logic signed [31:0] yh3_reg, hw2_3_reg, lw1_3_reg, lw2_3_reg;
    logic signed [55:0] ha1y4_reg, ha2y4_reg, lgx4_reg;
    logic signed [31:0] hw2_4_reg, lw1_4_reg, lw2_4_reg;
    logic signed [31:0] hn1_5_reg, hn2_5_reg, yl5_reg, lw2_5_reg;
    logic signed [55:0] lgx5_reg;
    logic signed [31:0] hn1_6_reg, hn2_6_reg, yl6_reg, lw2_6_reg;
    logic signed [55:0] lgx6_reg, la1y6_reg, la2y6_reg;

    logic signed [47:0] gx_c;
    logic signed [31:0] yh_c, hn1_c, hn2_c, yl_c, ln1_c, ln2_c;
    logic signed [55:0] ha1y_c, ha2y_c, lgx_c, la1y_c, la2y_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < tbbc_pkg::PIPE_DEPTH; k++)
                tag_reg[k] <= '0;
        end
        else
        begin
            tag_reg[0] <= tag_in;
            for (int k = 1; k < tbbc_pkg::PIPE_DEPTH; k++)
                tag_reg[k] <= tag_reg[k-1];
        end
    end

    assign gx_c   = $signed({1'b0, coef.hp_gain}) * x1_reg;
    assign yh_c   = tbbc_pkg::sat32(tbbc_pkg::rnd22(64'(gx2_reg)) + 64'(st2_reg.hp_w1));
    assign ha1y_c = coef.hp_a1 * yh3_reg;
    assign ha2y_c = coef.hp_a2 * yh3_reg;
    assign lgx_c  = $signed({1'b0, coef.lp_gain}) * yh3_reg;
    assign hn1_c  = tbbc_pkg::sat32(tbbc_pkg::rnd22(-(64'(gx4_reg) <<< 1) - 64'(ha1y4_reg))
                                    + 64'(hw2_4_reg));
    assign hn2_c  = tbbc_pkg::sat32(tbbc_pkg::rnd22(64'(gx4_reg) - 64'(ha2y4_reg)));
    assign yl_c   = tbbc_pkg::sat32(tbbc_pkg::rnd22(64'(lgx4_reg)) + 64'(lw1_4_reg));
    assign la1y_c = coef.lp_a1 * yl5_reg;
    assign la2y_c = coef.lp_a2 * yl5_reg;
    assign ln1_c  = tbbc_pkg::sat32(tbbc_pkg::rnd22((64'(lgx6_reg) <<< 1) - 64'(la1y6_reg))
                                    + 64'(lw2_6_reg));
    assign ln2_c  = tbbc_pkg::sat32(tbbc_pkg::rnd22(64'(lgx6_reg) - 64'(la2y6_reg)));

    always_ff @(posedge clk)
    begin
        x1_reg    <= {sample, 8'h00};
        gx2_reg   <= gx_c;
        st2_reg   <= rdata;
        yh3_reg   <= yh_c;
        gx3_reg   <= gx2_reg;
        hw2_3_reg <= st2_reg.hp_w2;
        lw1_3_reg <= st2_reg.lp_w1;
        lw2_3_reg <= st2_reg.lp_w2;
        ha1y4_reg <= ha1y_c;
        ha2y4_reg <= ha2y_c;
        lgx4_reg  <= lgx_c;
        gx4_reg   <= gx3_reg;
        hw2_4_reg <= hw2_3_reg;
        lw1_4_reg <= lw1_3_reg;
        lw2_4_reg <= lw2_3_reg;
        hn1_5_reg <= hn1_c;
        hn2_5_reg <= hn2_c;
        yl5_reg   <= yl_c;
        lgx5_reg  <= lgx4_reg;
        lw2_5_reg <= lw2_4_reg;
        hn1_6_reg <= hn1_5_reg;
        hn2_6_reg <= hn2_5_reg;
        yl6_reg   <= yl5_reg;
        lgx6_reg  <= lgx5_reg;
        lw2_6_reg <= lw2_5_reg;
        la1y6_reg <= la1y_c;
        la2y6_reg <= la2y_c;
    end

    // Hold any new item whose position still has a write-back in flight.
    always_comb
    begin
        hazard = 1'b0;
        for (int k = 0; k < tbbc_pkg::PIPE_DEPTH; k++)
            if (tag_reg[k].vld && !tag_reg[k].err && tag_reg[k].pos == probe_pos)
                hazard = 1'b1;
    end

    assign wr.we        = tag_reg[tbbc_pkg::PIPE_DEPTH-1].vld
                          && !tag_reg[tbbc_pkg::PIPE_DEPTH-1].err;
    assign wr.addr      = tag_reg[tbbc_pkg::PIPE_DEPTH-1].pos;
    assign wr.data      = '{hp_w1: hn1_6_reg, hp_w2: hn2_6_reg, lp_w1: ln1_c, lp_w2: ln2_c};
    assign push         = tag_reg[tbbc_pkg::PIPE_DEPTH-1].vld;
    assign result.filtered_sample = tag_reg[tbbc_pkg::PIPE_DEPTH-1].err ? 16'sd0
                                    : tbbc_pkg::out16(yl6_reg);
    assign result.ready_res       = tag_reg[tbbc_pkg::PIPE_DEPTH-1].rdy;
    assign result.position_error  = tag_reg[tbbc_pkg::PIPE_DEPTH-1].err;
endmodule
`default_nettype wire

/* rtl/core/tbbc_out_fifo.sv */
// Result queue between the pipeline and the output channel.
// Depends on tbbc_pkg.
`default_nettype none
module tbbc_out_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire tbbc_pkg::result_t push_data,
    output logic                   valid,
    input  wire logic              stall,
    output tbbc_pkg::result_t      data
);
    tbbc_pkg::result_t entry_reg [tbbc_pkg::FIFO_DEPTH];
    logic [tbbc_pkg::FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [tbbc_pkg::OCC_W-1:0]   count_reg, count_next;
    logic                         pop;

    assign valid = (count_reg != '0);
    assign pop   = valid && !stall;
    assign data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end
endmodule
`default_nettype wire

/* verif/temporal_bandpass_biquad_cascade_top_tb.sv */
// Self-checking testbench for the temporal band-pass biquad cascade.
// Depends on tbbc_pkg and temporal_bandpass_biquad_cascade_top.
module temporal_bandpass_biquad_cascade_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1500000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    tbbc_pkg::sample_in_t sample_item = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    tbbc_pkg::result_t    result_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [tbbc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tbbc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    temporal_bandpass_biquad_cascade_top uut (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_stall(sample_stall),
        .sample_item(sample_item),
        .result_valid(result_valid), .result_stall(result_stall),
        .result_item(result_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Predictor state: coefficients, frame settings and per-position filter memory.
    longint  hp_g, hp_fb1, hp_fb2, lp_g, lp_fb1, lp_fb2;
    int      pos_limit, warmup_thr;
    int      frames_done;
    int      hp_w1 [tbbc_pkg::MAX_POSITIONS];
    int      hp_w2 [tbbc_pkg::MAX_POSITIONS];
    int      lp_w1 [tbbc_pkg::MAX_POSITIONS];
    int      lp_w2 [tbbc_pkg::MAX_POSITIONS];

    tbbc_pkg::sample_in_t pending_samples[$];
    tbbc_pkg::result_t    expected_results[$];
    int         mismatches = 0;
    int         results_seen = 0;
    int         errors_seen = 0;
    longint     cycles = 0;

    function automatic longint round22(longint v);
        return (v + 64'sd2097152) >>> 22;
    endfunction

    function automatic int clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return int'(v);
    endfunction

    // One transposed direct-form II section; updates its two state words.
    function automatic int biquad(longint b0, longint b1, longint b2, longint a1,
                                  longint a2, ref int w1, ref int w2, input longint x);
        int y;
        int n1;
        int n2;
        y  = clamp32(round22(b0 * x) + longint'(w1));
        n1 = clamp32(round22(b1 * x - a1 * longint'(y)) + longint'(w2));
        n2 = clamp32(round22(b2 * x - a2 * longint'(y)));
        w1 = n1;
        w2 = n2;
        return y;
    endfunction

    function automatic tbbc_pkg::result_t bandpass_result(tbbc_pkg::sample_in_t s);
        tbbc_pkg::result_t r;
        int      hpo;
        int      lpo;
        longint  q;
        int      lim;
        int      thr;
        lim = (pos_limit > tbbc_pkg::MAX_POSITIONS) ? tbbc_pkg::MAX_POSITIONS : pos_limit;
        thr = (warmup_thr < 16) ? 16 : warmup_thr;
        r = '0;
        if (int'(s.position) >= lim) begin
            r.position_error = 1'b1;
        end
        else begin
            hpo = biquad(hp_g, -2 * hp_g, hp_g, hp_fb1, hp_fb2,
                         hp_w1[s.position], hp_w2[s.position],
                         longint'(s.sample) * 256);
            lpo = biquad(lp_g, 2 * lp_g, lp_g, lp_fb1, lp_fb2,
                         lp_w1[s.position], lp_w2[s.position], longint'(hpo));
            q = (longint'(lpo) + 128) >>> 8;
            if (q > 32767)
                q = 32767;
            if (q < -32768)
                q = -32768;
            r.filtered_sample = q[15:0];
            if (int'(s.position) == lim - 1 && frames_done < 65535)
                frames_done++;
        end
        r.ready_res = (frames_done >= thr);
        return r;
    endfunction

    function automatic void apply_setting(tbbc_pkg::cfg_reg_t idx,
                                          logic [tbbc_pkg::CFG_DATA_W-1:0] v);
        case (idx)
            tbbc_pkg::CFG_HP_GAIN:   hp_g = longint'(v[22:0]);
            tbbc_pkg::CFG_HP_A1:     hp_fb1 = longint'($signed(v));
            tbbc_pkg::CFG_HP_A2:     hp_fb2 = longint'($signed(v));
            tbbc_pkg::CFG_LP_GAIN:   lp_g = longint'(v[22:0]);
            tbbc_pkg::CFG_LP_A1:     lp_fb1 = longint'($signed(v));
            tbbc_pkg::CFG_LP_A2:     lp_fb2 = longint'($signed(v));
            tbbc_pkg::CFG_POSITIONS: pos_limit = int'(v[14:0]);
            tbbc_pkg::CFG_WARMUP:    warmup_thr = int'(v[15:0]);
            default: ;
        endcase
    endfunction

    // Write one register; drive on the falling edge, hold until the transfer.
    task automatic write_reg(logic [tbbc_pkg::CFG_IDX_W-1:0] idx, int v);
        logic [tbbc_pkg::CFG_DATA_W-1:0] d;
        d = v[tbbc_pkg::CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx <= tbbc_pkg::CFG_WARMUP)
            apply_setting(tbbc_pkg::cfg_reg_t'(idx), d);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait for the queue, the driver and the expected results to drain, then let the pipeline settle.
    task automatic wait_idle();
        while (pending_samples.size() != 0 || sample_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_filter(int hg, int h1, int h2, int lg, int l1, int l2);
        write_reg(tbbc_pkg::CFG_HP_GAIN, hg);
        write_reg(tbbc_pkg::CFG_HP_A1, h1);
        write_reg(tbbc_pkg::CFG_HP_A2, h2);
        write_reg(tbbc_pkg::CFG_LP_GAIN, lg);
        write_reg(tbbc_pkg::CFG_LP_A1, l1);
        write_reg(tbbc_pkg::CFG_LP_A2, l2);
    endtask

    function automatic void push_sample(int pos, int smp);
        tbbc_pkg::sample_in_t s;
        s.position = pos[13:0];
        s.sample   = smp[15:0];
        pending_samples.push_back(s);
    endfunction

    function automatic int rand_sample();
        case ($urandom_range(0, 5))
            0: return 32767;
            1: return -32768;
            2: return $urandom_range(0, 31) - 16;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // Record whether the input was stalled at the last rising edge.
    logic sample_stall_q = 1'b1;
    bit   stall_phase = 1'b0;

    // Driver: advance to the next queued item after each transfer, with random gaps.
    int gap = 0;
    always @(negedge clk) begin
        if (rst_n) begin
            if (sample_valid && !sample_stall_q) begin
                if (pending_samples.size() != 0 && gap == 0 && $urandom_range(0, 3) != 0) begin
                    sample_item <= pending_samples.pop_front();
                end
                else begin
                    sample_valid <= 1'b0;
                    gap = $urandom_range(0, 14);
                end
            end
            else if (!sample_valid) begin
                if (gap > 0)
                    gap--;
                else if (pending_samples.size() != 0) begin
                    sample_valid <= 1'b1;
                    sample_item  <= pending_samples.pop_front();
                end
            end
        end
    end

    always @(posedge clk) begin
        sample_stall_q <= sample_stall;
        if (rst_n && sample_valid && !sample_stall)
            expected_results.push_back(bandpass_result(sample_item));
    end

    // Monitor: compare each result transfer against the oldest prediction.
    int stall_left = 0;
    always @(posedge clk) begin
        tbbc_pkg::result_t e;
        if (rst_n && result_valid && !result_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result %h", $time, result_item);
            end
            else begin
                e = expected_results.pop_front();
                if (result_item.position_error) errors_seen++;
                if (e.filtered_sample !== result_item.filtered_sample
                    || e.ready_res !== result_item.ready_res
                    || e.position_error !== result_item.position_error) begin
                    mismatches++;
                    $display("%0t: expected sample %0d ready %b err %b, got %0d %b %b",
                             $time, e.filtered_sample, e.ready_res, e.position_error,
                             result_item.filtered_sample, result_item.ready_res,
                             result_item.position_error);
                end
            end
        end
    end

    // Output stall: hold for a random count after some result transfers, else stall at random.
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if (result_valid && !result_stall && $urandom_range(0, 2) == 0) begin
            stall_left = $urandom_range(0, 14);
            result_stall <= (stall_left > 0);
        end
        else
            result_stall <= stall_phase ? 1'b0 : ($urandom_range(0, 7) == 0);
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int n;
        int p;
        hp_g = 0; hp_fb1 = 0; hp_fb2 = 0; lp_g = 0; lp_fb1 = 0; lp_fb2 = 0;
        pos_limit = 16384; warmup_thr = 16; frames_done = 0;
        foreach (hp_w1[i]) begin
            hp_w1[i] = 0; hp_w2[i] = 0; lp_w1[i] = 0; lp_w2[i] = 0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: pass-through-ish gains with zero feedback, extremes and range errors.
        write_reg(tbbc_pkg::CFG_POSITIONS, 4);
        write_reg(tbbc_pkg::CFG_WARMUP, 0);
        write_filter(4194304, 0, 0, 4194304, 0, 0);
        push_sample(0, 32767);
        push_sample(1, -32768);
        push_sample(2, 0);
        push_sample(3, 1);
        push_sample(4, 100);
        push_sample(16383, -1);
        for (int i = 0; i < 12; i++)
            push_sample(i % 4, (i & 1) ? 32767 : -32768);
        wait_idle();

        // Saturating feedback extremes, a zero-position frame, an unmapped register write and the full position range.
        write_filter(4194304, 8388607, -8388608, 4194304, -8388608, 8388607);
        for (int i = 0; i < 6; i++)
            push_sample(i % 4, 32767);
        wait_idle();
        write_reg(tbbc_pkg::CFG_POSITIONS, 0);
        push_sample(0, 5);
        wait_idle();
        write_reg(4'd9, 24'h123456);
        write_reg(tbbc_pkg::CFG_POSITIONS, 16384);
        push_sample(16383, 1234);
        push_sample(16383, -1234);
        wait_idle();

        // Random phases: small frames with stable band-pass coefficients, fully random ones in the last phase.
        for (int ph = 0; ph < 6; ph++) begin
            n = $urandom_range(1, 12);
            if (ph == 2)
                write_reg(tbbc_pkg::CFG_WARMUP, 65535);
            else
                write_reg(tbbc_pkg::CFG_WARMUP, $urandom_range(0, 40));
            write_reg(tbbc_pkg::CFG_POSITIONS, n);
            if (ph == 5)
                write_filter($urandom_range(0, 4194304), $urandom_range(0, 16777215),
                             $urandom_range(0, 16777215), $urandom_range(0, 4194304),
                             $urandom_range(0, 16777215), $urandom_range(0, 16777215));
            else
                write_filter($urandom_range(2000000, 4194304),
                             -$urandom_range(6000000, 8388607),
                             $urandom_range(2000000, 4000000),
                             $urandom_range(1000, 500000),
                             -$urandom_range(6000000, 8388607),
                             $urandom_range(2000000, 4000000));
            stall_phase = (ph == 1);
            for (int i = 0; i < 210; i++) begin
                if ($urandom_range(0, 19) == 0)
                    p = $urandom_range(0, 16383);
                else
                    p = i % n;
                push_sample(p, rand_sample());
            end
            wait_idle();
        end
        stall_phase = 1'b0;

        $display("covered %0d results, %0d range errors, %0d frames counted",
                 results_seen, errors_seen, frames_done);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
